[hw/rtl/hvd_pkg.sv]
// Package for the haversine distance pipeline: types, fixed-point constants, arctangent table.
package hvd_pkg;

    // Default number of CORDIC iterations and fixed sqrt iterations
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int SQRT_STEPS       = 32;

    // Degrees*1e7 to radians Q3.29 scale: round(pi/180/1e7 * 2^59)
    localparam logic [29:0] RAD_K = 30'd1006113814;
    localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
    localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
    localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;

    // Radius register and output limits
    localparam logic [32:0] MM_PER_M          = 33'd1000;
    localparam logic [32:0] DEFAULT_RADIUS_MM = 33'd6371000000;
    localparam logic [36:0] DIST_MAX          = 37'd34359738367;

    // One CORDIC lane: x, y and angle residue
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_rot;

    // One square-root lane: remainder and partial root
    typedef struct packed {
        logic [63:0] n;
        logic [63:0] res;
    } t_sqrt;

    // atan(2^-i) in Q1.30, truncated
    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/hvd_rot_stage.sv]
// One CORDIC rotation iteration over the four angle lanes, registered.
module hvd_rot_stage #(
    parameter int STEP = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hvd_pkg::t_rot [3:0] i_lane,
    input  logic [3:0]         i_neg,
    output logic               o_valid,
    output hvd_pkg::t_rot [3:0] o_lane,
    output logic [3:0]         o_neg
);

    localparam logic signed [33:0] ATAN = $signed({2'b00, hvd_pkg::atan_q30(STEP)});

    logic               r_valid;
    hvd_pkg::t_rot [3:0] r_lane;
    logic [3:0]         r_neg;
    hvd_pkg::t_rot [3:0] n_lane;

    // rotate toward zero residue
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (!i_lane[k].z[33]) begin
                n_lane[k].x = i_lane[k].x - (i_lane[k].y >>> STEP);
                n_lane[k].y = i_lane[k].y + (i_lane[k].x >>> STEP);
                n_lane[k].z = i_lane[k].z - ATAN;
            end else begin
                n_lane[k].x = i_lane[k].x + (i_lane[k].y >>> STEP);
                n_lane[k].y = i_lane[k].y - (i_lane[k].x >>> STEP);
                n_lane[k].z = i_lane[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
        r_neg  <= i_neg;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
    assign o_neg   = r_neg;

endmodule

[hw/rtl/hvd_sqrt_stage.sv]
// One bit step of the restoring square root over two lanes, registered.
module hvd_sqrt_stage #(
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  hvd_pkg::t_sqrt [1:0] i_lane,
    output logic                o_valid,
    output hvd_pkg::t_sqrt [1:0] o_lane
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic                r_valid;
    hvd_pkg::t_sqrt [1:0] r_lane;
    hvd_pkg::t_sqrt [1:0] n_lane;
    logic [63:0]         w_trial [2];

    // trial subtract of res + bit
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_trial[k] = i_lane[k].res + BIT;
            if (i_lane[k].n >= w_trial[k]) begin
                n_lane[k].n   = i_lane[k].n - w_trial[k];
                n_lane[k].res = (i_lane[k].res >> 1) + BIT;
            end else begin
                n_lane[k].n   = i_lane[k].n;
                n_lane[k].res = i_lane[k].res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

[hw/rtl/hvd_vec_stage.sv]
// One CORDIC vectoring iteration for the final atan2, registered.
module hvd_vec_stage #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  hvd_pkg::t_rot i_lane,
    output logic          o_valid,
    output hvd_pkg::t_rot o_lane
);

    localparam logic signed [33:0] ATAN = $signed({2'b00, hvd_pkg::atan_q30(STEP)});

    logic          r_valid;
    hvd_pkg::t_rot r_lane;
    hvd_pkg::t_rot n_lane;

    // drive y toward zero, accumulate angle
    always_comb begin
        if (!i_lane.y[33]) begin
            n_lane.x = i_lane.x + (i_lane.y >>> STEP);
            n_lane.y = i_lane.y - (i_lane.x >>> STEP);
            n_lane.z = i_lane.z + ATAN;
        end else begin
            n_lane.x = i_lane.x - (i_lane.y >>> STEP);
            n_lane.y = i_lane.y + (i_lane.x >>> STEP);
            n_lane.z = i_lane.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

[hw/rtl/haversine_distance.sv]
// Top level: pipelined haversine great-circle distance with a radius register.
//
//  channel   direction  handshake                 payload
//  ------    ---------  ------------------------  ------------------------------------
//  command   in         start / busy              i_lat_first, i_lon_first,
//                                                 i_lat_second, i_lon_second
//  result    out        o_valid (strobe)          o_distance_mm
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_data (radius in metres)
//
// One transaction enters per cycle; busy is never raised.
// Stages in order: front end, sin/cos CORDIC, sign fix, products and clamp,
// square root, atan2 CORDIC, scale and round.
// Synchronous active-low reset clears the valid pipeline and loads the default radius.
// The receiver cannot stall: each result is shown for exactly one cycle.
module haversine_distance #(
    parameter int CORDIC_STEPS = hvd_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [30:0] i_lat_first,
    input  logic signed [31:0] i_lon_first,
    input  logic signed [30:0] i_lat_second,
    input  logic signed [31:0] i_lon_second,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [22:0]        i_cfg_data,
    output logic               o_valid,
    output logic [34:0]        o_distance_mm
);

    localparam int LATENCY = 2 * CORDIC_STEPS + 43;

    logic w_accept;
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;

    // radius register, kept in millimetres
    logic [32:0] r_radius_mm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_mm <= hvd_pkg::DEFAULT_RADIUS_MM;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_radius_mm <= 33'(i_cfg_data) * hvd_pkg::MM_PER_M;
        end
    end

    // front-end valid chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_v6, r_v7, r_v8, r_v9;
    logic r_vp, r_vo;
    logic w_rot_v [CORDIC_STEPS+1];
    logic w_sq_v  [hvd_pkg::SQRT_STEPS+1];
    logic w_vec_v [CORDIC_STEPS+1];

    // stage 1: angle differences (lane 0 dlat, 1 dlon, 2 lat1, 3 lat2)
    logic signed [32:0] r1_d [4];
    always_ff @(posedge i_clk) begin
        r1_d[0] <= 33'(i_lat_second) - 33'(i_lat_first);
        r1_d[1] <= 33'(i_lon_second) - 33'(i_lon_first);
        r1_d[2] <= 33'(i_lat_first);
        r1_d[3] <= 33'(i_lat_second);
    end

    // stage 2: magnitude and sign
    logic [32:0] r2_mag [4];
    logic [3:0]  r2_sgn;
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r2_sgn[k] <= r1_d[k][32];
            r2_mag[k] <= r1_d[k][32] ? 33'(-r1_d[k]) : 33'(r1_d[k]);
        end
    end

    // stage 3: scale to radians
    logic [62:0] r3_prod [4];
    logic [3:0]  r3_sgn;
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r3_prod[k] <= 63'(r2_mag[k]) * 63'(hvd_pkg::RAD_K);
        end
        r3_sgn <= r2_sgn;
    end

    // stage 4: round half away from zero, restore sign; differences are half angles
    logic signed [33:0] r4_theta [4];
    logic [33:0]        w4_p [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (k < 2) begin
                w4_p[k] = 34'((64'(r3_prod[k]) + (64'd1 << 30)) >> 31);
            end else begin
                w4_p[k] = 34'((64'(r3_prod[k]) + (64'd1 << 29)) >> 30);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r4_theta[k] <= r3_sgn[k] ? -$signed(w4_p[k]) : $signed(w4_p[k]);
        end
    end

    // stage 5: fold into [-pi/2, pi/2], load CORDIC start vector
    hvd_pkg::t_rot [3:0] r5_lane;
    logic [3:0]          r5_neg;
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r5_lane[k].x <= hvd_pkg::INV_GAIN_Q30;
            r5_lane[k].y <= '0;
            if (r4_theta[k] > hvd_pkg::HALF_PI_Q29) begin
                r5_lane[k].z <= (r4_theta[k] - hvd_pkg::PI_Q29) <<< 1;
                r5_neg[k]    <= 1'b1;
            end else if (r4_theta[k] < -hvd_pkg::HALF_PI_Q29) begin
                r5_lane[k].z <= (r4_theta[k] + hvd_pkg::PI_Q29) <<< 1;
                r5_neg[k]    <= 1'b1;
            end else begin
                r5_lane[k].z <= r4_theta[k] <<< 1;
                r5_neg[k]    <= 1'b0;
            end
        end
    end

    // sin/cos CORDIC chain
    hvd_pkg::t_rot [3:0] w_rot_lane [CORDIC_STEPS+1];
    logic [3:0]          w_rot_neg  [CORDIC_STEPS+1];
    assign w_rot_v[0]    = r_v5;
    assign w_rot_lane[0] = r5_lane;
    assign w_rot_neg[0]  = r5_neg;
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
        hvd_rot_stage #(.STEP(g)) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_rot_v[g]),
            .i_lane  (w_rot_lane[g]),
            .i_neg   (w_rot_neg[g]),
            .o_valid (w_rot_v[g+1]),
            .o_lane  (w_rot_lane[g+1]),
            .o_neg   (w_rot_neg[g+1])
        );
    end

    // stage 6: apply fold sign; keep sin of half differences, cos of latitudes
    logic signed [31:0] r6_s1, r6_s2, r6_ca, r6_cb;
    hvd_pkg::t_rot [3:0] w_rf;
    logic [3:0]          w_nf;
    assign w_rf = w_rot_lane[CORDIC_STEPS];
    assign w_nf = w_rot_neg[CORDIC_STEPS];
    always_ff @(posedge i_clk) begin
        r6_s1 <= 32'(w_nf[0] ? -w_rf[0].y : w_rf[0].y);
        r6_s2 <= 32'(w_nf[1] ? -w_rf[1].y : w_rf[1].y);
        r6_ca <= 32'(w_nf[2] ? -w_rf[2].x : w_rf[2].x);
        r6_cb <= 32'(w_nf[3] ? -w_rf[3].x : w_rf[3].x);
    end

    // stage 7: squares and cosine product
    logic signed [63:0] w7_p1, w7_p2, w7_pc;
    logic [31:0]        r7_sq1, r7_sq2;
    logic signed [32:0] r7_cc;
    assign w7_p1 = 64'(r6_s1) * 64'(r6_s1);
    assign w7_p2 = 64'(r6_s2) * 64'(r6_s2);
    assign w7_pc = 64'(r6_ca) * 64'(r6_cb);
    always_ff @(posedge i_clk) begin
        r7_sq1 <= w7_p1[61:30];
        r7_sq2 <= w7_p2[61:30];
        r7_cc  <= w7_pc[62:30];
    end

    // stage 8: sin^2(dlon/2) * cos * cos
    logic signed [65:0] w8_t;
    logic signed [33:0] r8_t;
    logic [31:0]        r8_sq1;
    assign w8_t = 66'($signed({1'b0, r7_sq2})) * 66'(r7_cc);
    always_ff @(posedge i_clk) begin
        r8_t   <= w8_t[63:30];
        r8_sq1 <= r7_sq1;
    end

    // stage 9: a = sum clamped to [0, 1], and 1 - a
    logic signed [34:0] w9_a;
    logic [30:0]        w9_ac;
    logic [30:0]        r9_a, r9_b;
    assign w9_a = 35'($signed({1'b0, r8_sq1})) + 35'(r8_t);
    always_comb begin
        if (w9_a[34]) begin
            w9_ac = '0;
        end else if (w9_a > 35'($signed({1'b0, hvd_pkg::ONE_Q30}))) begin
            w9_ac = hvd_pkg::ONE_Q30;
        end else begin
            w9_ac = w9_a[30:0];
        end
    end
    always_ff @(posedge i_clk) begin
        r9_a <= w9_ac;
        r9_b <= hvd_pkg::ONE_Q30 - w9_ac;
    end

    // square root chain, lane 0 sqrt(a), lane 1 sqrt(1-a)
    hvd_pkg::t_sqrt [1:0] w_sq_lane [hvd_pkg::SQRT_STEPS+1];
    assign w_sq_v[0]          = r_v9;
    assign w_sq_lane[0][0].n   = 64'(r9_a) << 30;
    assign w_sq_lane[0][0].res = '0;
    assign w_sq_lane[0][1].n   = 64'(r9_b) << 30;
    assign w_sq_lane[0][1].res = '0;
    for (genvar g = 0; g < hvd_pkg::SQRT_STEPS; g++) begin : g_sqrt
        hvd_sqrt_stage #(.STEP(g)) u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sq_v[g]),
            .i_lane  (w_sq_lane[g]),
            .o_valid (w_sq_v[g+1]),
            .o_lane  (w_sq_lane[g+1])
        );
    end

    // atan2 vectoring chain
    hvd_pkg::t_rot w_vec_lane [CORDIC_STEPS+1];
    assign w_vec_v[0]      = w_sq_v[hvd_pkg::SQRT_STEPS];
    assign w_vec_lane[0].x = 34'(w_sq_lane[hvd_pkg::SQRT_STEPS][1].res);
    assign w_vec_lane[0].y = 34'(w_sq_lane[hvd_pkg::SQRT_STEPS][0].res);
    assign w_vec_lane[0].z = '0;
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
        hvd_vec_stage #(.STEP(g)) u_vec (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vec_v[g]),
            .i_lane  (w_vec_lane[g]),
            .o_valid (w_vec_v[g+1]),
            .o_lane  (w_vec_lane[g+1])
        );
    end

    // scale angle by radius; negative residue counts as zero
    logic signed [33:0] w_z;
    logic [31:0]        w_zc;
    logic [64:0]        r_prod;
    assign w_z  = w_vec_lane[CORDIC_STEPS].z;
    assign w_zc = w_z[33] ? 32'd0 : w_z[31:0];
    always_ff @(posedge i_clk) begin
        r_prod <= 65'(r_radius_mm) * 65'(w_zc);
    end

    // round to millimetres and saturate
    logic [36:0] w_dist;
    logic [34:0] r_dist;
    assign w_dist = 37'((66'(r_prod) + (66'd1 << 28)) >> 29);
    always_ff @(posedge i_clk) begin
        r_dist <= (w_dist > hvd_pkg::DIST_MAX) ? hvd_pkg::DIST_MAX[34:0] : w_dist[34:0];
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
            r_vp <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= w_rot_v[CORDIC_STEPS];
            r_v7 <= r_v6;
            r_v8 <= r_v7;
            r_v9 <= r_v8;
            r_vp <= w_vec_v[CORDIC_STEPS];
            r_vo <= r_vp;
        end
    end

    assign o_valid       = r_vo;
    assign o_distance_mm = r_dist;

    // a and 1 - a add up to one and a stays in the unit interval
    function automatic logic unit_sum_ok(input logic [30:0] a, input logic [30:0] b);
        return (a <= hvd_pkg::ONE_Q30) && ((a + b) == hvd_pkg::ONE_Q30);
    endfunction

    // every result traces back to an earlier accepted transaction
    a_out_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LATENCY))
        else $error("result strobe without matching transaction");

    // every accepted transaction yields a later result
    a_cmd_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_valid)
        else $error("transaction lost in pipeline");

    // a radius write lands scaled to millimetres
    a_radius_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=>
            (r_radius_mm == 33'($past(i_cfg_data)) * hvd_pkg::MM_PER_M))
        else $error("radius register not updated");

    // a clamped to the unit interval
    a_a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v9 |-> (unit_sum_ok(r9_a, r9_b)))
        else $error("haversine term out of range");

endmodule

[sim/tb_haversine_distance.sv]
// Testbench for the haversine distance pipeline: directed table, random pairs, radius changes.
`timescale 1ns / 1ps

module tb_haversine_distance;

    localparam int STEPS   = hvd_pkg::CORDIC_STEPS_DEF;
    localparam int LATENCY = 2 * STEPS + 43;
    localparam int WDOG_MAX = 4000;
    localparam logic signed [63:0] PI_29   = 64'sd1686629713;
    localparam logic signed [63:0] HPI_29  = 64'sd843314857;
    localparam logic signed [63:0] GAIN_30 = 64'sd652032874;
    localparam logic signed [63:0] ONE_30  = 64'sd1073741824;
    localparam logic [63:0] RADK = 64'd1006113814;
    localparam logic [63:0] DMAX = 64'd34359738367;
    localparam logic [63:0] NO_CHECK = '1;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [30:0] i_lat_first;
    logic signed [31:0] i_lon_first;
    logic signed [30:0] i_lat_second;
    logic signed [31:0] i_lon_second;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [22:0]        i_cfg_data;
    logic               o_valid;
    logic [34:0]        o_distance_mm;

    logic [34:0] dist_queue[$];
    logic [22:0] radius_m;
    int          errors;
    int          idle_cycles;

    haversine_distance u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_lat_first   (i_lat_first),
        .i_lon_first   (i_lon_first),
        .i_lat_second  (i_lat_second),
        .i_lon_second  (i_lon_second),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_distance_mm (o_distance_mm)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---- predictor ----
    function automatic logic signed [63:0] fshift(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] deg_to_rad(logic signed [63:0] d, int sh);
        logic [63:0] mag;
        logic [63:0] p;
        mag = (d < 0) ? -d : d;
        p = (mag * RADK + (64'd1 << (sh - 1))) >> sh;
        return (d < 0) ? -$signed(p) : $signed(p);
    endfunction

    task automatic rotate(input logic signed [63:0] th,
                          output logic signed [63:0] s, output logic signed [63:0] c);
        logic neg;
        logic signed [63:0] x, y, z, dx, dy;
        neg = 1'b0;
        x = GAIN_30;
        y = 0;
        if (th > HPI_29) begin
            th = th - PI_29;
            neg = 1'b1;
        end else if (th < -HPI_29) begin
            th = th + PI_29;
            neg = 1'b1;
        end
        z = th * 2;
        for (int i = 0; i < STEPS; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - $signed({32'd0, hvd_pkg::atan_q30(i)});
            end else begin
                x = x + dx; y = y - dy; z = z + $signed({32'd0, hvd_pkg::atan_q30(i)});
            end
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endtask

    function automatic logic [63:0] root_q30(logic [63:0] v);
        logic [63:0] n, res, bt;
        n = v << 30;
        res = 0;
        bt = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (n >= res + bt) begin
                n = n - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] vector_angle(logic signed [63:0] y,
                                                        logic signed [63:0] x);
        logic signed [63:0] z, dx, dy;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + $signed({32'd0, hvd_pkg::atan_q30(i)});
            end else begin
                x = x - dx; y = y + dy; z = z - $signed({32'd0, hvd_pkg::atan_q30(i)});
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    task automatic predict_distance(input logic signed [30:0] la1, input logic signed [31:0] lo1,
                                    input logic signed [30:0] la2, input logic signed [31:0] lo2,
                                    output logic [34:0] dist_mm);
        logic signed [63:0] s1, c1, s2, c2, sa, ca, sb, cb, cc, a, t, z;
        logic [63:0] sq1, sq2, r_mm, d;
        rotate(deg_to_rad(64'(la2) - 64'(la1), 31), s1, c1);
        rotate(deg_to_rad(64'(lo2) - 64'(lo1), 31), s2, c2);
        rotate(deg_to_rad(64'(la1), 30), sa, ca);
        rotate(deg_to_rad(64'(la2), 30), sb, cb);
        sq1 = (s1 * s1) >> 30;
        sq2 = (s2 * s2) >> 30;
        cc = fshift(ca * cb, 30);
        t = fshift($signed(sq2) * cc, 30);
        a = $signed(sq1) + t;
        if (a < 0) a = 0;
        if (a > ONE_30) a = ONE_30;
        z = vector_angle($signed(root_q30(a)), $signed(root_q30(ONE_30 - a)));
        r_mm = 64'(radius_m) * 64'd1000;
        d = (r_mm * z + (64'd1 << 28)) >> 29;
        if (d > DMAX) d = DMAX;
        dist_mm = d[34:0];
    endtask

    // ---- result checker ----
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (dist_queue.size() == 0) begin
                $display("%0t: unexpected result distance_mm=%0d", $time, o_distance_mm);
                errors++;
            end else begin
                if (o_distance_mm !== dist_queue[0]) begin
                    $display("%0t: distance_mm mismatch expected=%0d actual=%0d",
                             $time, dist_queue[0], o_distance_mm);
                    errors++;
                end
                void'(dist_queue.pop_front());
            end
        end
    end

    // ---- watchdog: cycles with no transaction ----
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---- stimulus helpers ----
    // start stays high after the accepting edge so that back-to-back items need no gap
    task automatic send_pair(input logic signed [30:0] la1, input logic signed [31:0] lo1,
                             input logic signed [30:0] la2, input logic signed [31:0] lo2,
                             input logic [63:0] fixed_mm, input bit gaps);
        logic [34:0] d;
        int gap;
        gap = gaps ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        predict_distance(la1, lo1, la2, lo2, d);
        if (fixed_mm != NO_CHECK)
            d = fixed_mm[34:0];
        start        <= 1'b1;
        i_lat_first  <= la1;
        i_lon_first  <= lo1;
        i_lat_second <= la2;
        i_lon_second <= lo2;
        do @(posedge i_clk); while (busy);
        dist_queue.push_back(d);
    endtask

    // Wait for the pipeline to drain, then the full latency, before a radius write
    task automatic write_radius(input logic [22:0] r);
        start <= 1'b0;
        wait (dist_queue.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        radius_m = r;
    endtask

    function automatic logic signed [30:0] rnd_lat(bit wide);
        if (wide) return $signed(31'($urandom));
        return 31'($signed($urandom_range(0, 1800000000)) - 900000000);
    endfunction

    function automatic logic signed [31:0] rnd_lon(bit wide);
        if (wide) return $signed($urandom);
        return $signed($urandom_range(0, 32'd3600000000)) - 32'sd1800000000;
    endfunction

    // Directed table: lat1, lon1, lat2, lon2, fixed distance (NO_CHECK = use predictor)
    typedef struct {
        logic signed [30:0] la1;
        logic signed [31:0] lo1;
        logic signed [30:0] la2;
        logic signed [31:0] lo2;
        logic [63:0]        exp_mm;
    } t_pair_row;

    t_pair_row pair_table[] = '{
        '{31'sd0, 32'sd0, 31'sd0, 32'sd0, NO_CHECK},
        '{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0, NO_CHECK},
        '{-31'sd900000000, -32'sd1800000000, 31'sd900000000, 32'sd1800000000, NO_CHECK},
        '{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000, NO_CHECK},
        '{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000, NO_CHECK},
        '{31'sd0, 32'sd0, 31'sd0, -32'sd900000000, NO_CHECK},
        '{31'sd473000000, 32'sd85000000, 31'sd473000000, 32'sd85000000, NO_CHECK},
        '{31'sd515000000, -32'sd1270000, 31'sd407000000, -32'sd740000000, NO_CHECK},
        '{31'sd0, 32'sd0, 31'sd1, 32'sd1, NO_CHECK},
        '{31'h3FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 32'h80000000, NO_CHECK},
        '{31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF, NO_CHECK},
        '{31'h7FFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF, NO_CHECK},
        '{-31'sd337000000, 32'sd1512000000, 31'sd406000000, -32'sd739000000, NO_CHECK},
        '{31'sd899999999, 32'sd1234567, 31'sd899999999, -32'sd1765432100, NO_CHECK},
        '{31'h55555555, 32'hAAAAAAAA, 31'h2AAAAAAA, 32'h55555555, NO_CHECK}
    };

    logic [22:0] radius_set[] = '{23'd1, 23'd8388607, 23'd6371000, 23'd1737400, 23'd0};

    // ---- main sequence ----
    initial begin
        errors       = 0;
        idle_cycles  = 0;
        radius_m     = 23'd6371000;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        i_lat_first  = '0;
        i_lon_first  = '0;
        i_lat_second = '0;
        i_lon_second = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at the reset radius, back to back
        foreach (pair_table[k])
            send_pair(pair_table[k].la1, pair_table[k].lo1, pair_table[k].la2,
                      pair_table[k].lo2, pair_table[k].exp_mm, 1'b0);

        // Random phases across radius settings; radius zero gives zero distance
        foreach (radius_set[p]) begin
            write_radius(radius_set[p]);
            send_pair(31'sd0, 32'sd0, 31'sd900000000, 32'sd0,
                      (radius_set[p] == 0) ? 64'd0 : NO_CHECK, 1'b0);
            for (int n = 0; n < 180; n++) begin
                bit wide;
                logic signed [30:0] la1;
                logic signed [31:0] lo1;
                wide = ($urandom_range(0, 9) == 0);
                la1 = rnd_lat(wide);
                lo1 = rnd_lon(wide);
                if ($urandom_range(0, 7) == 0)
                    send_pair(la1, lo1, la1 + 31'($signed($urandom_range(0, 2000)) - 1000),
                              lo1 + ($signed($urandom_range(0, 2000)) - 1000),
                              NO_CHECK, $urandom_range(0, 3) != 0);
                else
                    send_pair(la1, lo1, rnd_lat(wide), rnd_lon(wide), NO_CHECK,
                              $urandom_range(0, 3) != 0);
            end
        end

        // Drain, then allow the pipeline latency
        start <= 1'b0;
        wait (dist_queue.size() == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (errors == 0 && dist_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
